// File: rtl/core/prc_pkg.sv
// Shared types, constants and helpers for the polygon rectangle clipper.
// No dependencies; imported by prc_cross_unit, polygon_rectangle_clipper and the testbench.
package prc_pkg;

   localparam int MAX_VERTS  = 64;
   localparam int COORD_BITS = 16;

   localparam int ADDR_W   = $clog2(MAX_VERTS);
   localparam int CNT_W    = $clog2(MAX_VERTS + 1);
   localparam int POINT_W  = 2 * COORD_BITS;
   localparam int TDATA_W  = ((POINT_W + 7) / 8) * 8;
   localparam int DIFF_W   = COORD_BITS + 1;
   localparam int PROD_W   = 2 * DIFF_W;
   localparam int NUM_W    = PROD_W + 1;
   localparam int DCNT_W   = $clog2(NUM_W + 1);
   localparam int CSR_IDX_W = 8;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [POINT_W-1:0] point_type;
   typedef logic [1:0] side_type;

   localparam coord_type COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   localparam side_type SIDE_TOP    = 2'd0;
   localparam side_type SIDE_BOTTOM = 2'd1;
   localparam side_type SIDE_LEFT   = 2'd2;
   localparam side_type SIDE_RIGHT  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_X_LOW  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_X_HIGH = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_Y_LOW  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_Y_HIGH = CSR_IDX_W'(3);

   // operands of a + (b - a) * (c - p) / (q - p)
   typedef struct packed {
      coord_type a;
      coord_type b;
      coord_type p;
      coord_type q;
      coord_type c;
   } cross_req_type;

   function automatic point_type pack_point(coord_type x, coord_type y);
      return {y, x};
   endfunction

   function automatic coord_type point_x(point_type pt);
      return coord_type'(pt[COORD_BITS-1:0]);
   endfunction

   function automatic coord_type point_y(point_type pt);
      return coord_type'(pt[POINT_W-1:COORD_BITS]);
   endfunction

endpackage

// File: rtl/core/prc_cross_unit.sv
// Edge/side crossing unit: one shared multiplier used twice, then a
// bit-serial restoring divider. Depends on prc_pkg.
module prc_cross_unit import prc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  cross_req_type req,
   output logic          done,
   output coord_type     result
);

   typedef enum logic [2:0] {CU_IDLE, CU_MUL1, CU_MUL2, CU_PREP, CU_DIV, CU_FIN} cu_state_type;

   cu_state_type state_ff;
   coord_type a_ff, b_ff, result_ff;
   logic signed [DIFF_W-1:0] d_ff, ba_ff, cp_ff;
   logic signed [NUM_W-1:0]  acc_ff;
   logic [NUM_W-1:0]  quo_ff;
   logic [DIFF_W-1:0] rem_ff, dvs_ff;
   logic              neg_ff, done_ff;
   logic [DCNT_W-1:0] cnt_ff;

   logic signed [DIFF_W-1:0] mul_x, mul_y;
   logic signed [PROD_W-1:0] mul_p;
   logic signed [NUM_W-1:0]  mul_ext, num_fix;
   logic signed [DIFF_W-1:0] d_abs;
   logic [DIFF_W:0]          trial;
   logic                     qbit;
   logic [NUM_W-1:0]         quo_sgn;

   always_comb begin
      mul_x = (state_ff == CU_MUL1) ? DIFF_W'(a_ff) : ba_ff;
      mul_y = (state_ff == CU_MUL1) ? d_ff : cp_ff;
      mul_p = mul_x * mul_y;
      mul_ext = {{(NUM_W-PROD_W){mul_p[PROD_W-1]}}, mul_p};
      num_fix = d_ff[DIFF_W-1] ? -acc_ff : acc_ff;
      d_abs   = d_ff[DIFF_W-1] ? -d_ff : d_ff;
      trial = {rem_ff, quo_ff[NUM_W-1]};
      qbit  = (trial >= {1'b0, dvs_ff});
      quo_sgn = neg_ff ? -quo_ff : quo_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CU_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            CU_IDLE: begin
               if (start) begin
                  a_ff  <= req.a;
                  b_ff  <= req.b;
                  d_ff  <= DIFF_W'(req.q) - DIFF_W'(req.p);
                  ba_ff <= DIFF_W'(req.b) - DIFF_W'(req.a);
                  cp_ff <= DIFF_W'(req.c) - DIFF_W'(req.p);
                  state_ff <= CU_MUL1;
               end
            end
            CU_MUL1: begin
               acc_ff   <= mul_ext;
               state_ff <= CU_MUL2;
            end
            CU_MUL2: begin
               acc_ff   <= acc_ff + mul_ext;
               state_ff <= CU_PREP;
            end
            CU_PREP: begin
               if (d_ff == '0) begin
                  result_ff <= b_ff;
                  done_ff   <= 1'b1;
                  state_ff  <= CU_IDLE;
               end else begin
                  neg_ff   <= num_fix[NUM_W-1];
                  quo_ff   <= num_fix[NUM_W-1] ? NUM_W'(-num_fix) : NUM_W'(num_fix);
                  rem_ff   <= '0;
                  dvs_ff   <= DIFF_W'(d_abs);
                  cnt_ff   <= DCNT_W'(NUM_W);
                  state_ff <= CU_DIV;
               end
            end
            CU_DIV: begin
               rem_ff <= qbit ? DIFF_W'(trial - {1'b0, dvs_ff}) : DIFF_W'(trial);
               quo_ff <= {quo_ff[NUM_W-2:0], qbit};
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == DCNT_W'(1)) state_ff <= CU_FIN;
            end
            CU_FIN: begin
               // quotient truncates toward zero, sign restored here
               result_ff <= coord_type'(quo_sgn[COORD_BITS-1:0]);
               done_ff   <= 1'b1;
               state_ff  <= CU_IDLE;
            end
            default: state_ff <= CU_IDLE;
         endcase
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

// File: rtl/core/polygon_rectangle_clipper.sv
// Top level: vertex load, two ping-pong vertex memories, side sequencer and
// result register. Depends on prc_pkg and prc_cross_unit.
//
//  channel | handshake             | payload
//  req     | req_tvalid/req_tready | tdata: vertex_x, vertex_y; tlast: last_vertex
//  rsp     | rsp_tvalid/rsp_tready | tdata: point_x, point_y; tlast: last_point;
//          |                       | tuser: overflow, degenerate
//  csr     | csr_valid/csr_ready   | index, data: clip_x_low/x_high/y_low/y_high
//
// Vertices are taken while req is open; after the closing vertex comes the box test,
// then the polygon is clipped side by side: each side reads its first vertex and walks
// every edge (edge, decide, next); an edge that crosses the side adds two multiplier
// passes and a 35-step serial divider; a two-point fallback writes its two points.
// Each result point is read, loaded, then held until taken; req is held off meanwhile.
// Reset returns control state and the clip rectangle to defaults; memory is not cleared.
module polygon_rectangle_clipper import prc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [TDATA_W-1:0]   req_tdata,   // vertex_x, vertex_y
   input  logic                 req_tlast,   // last_vertex
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [TDATA_W-1:0]   rsp_tdata,   // point_x, point_y
   output logic                 rsp_tlast,   // last_point
   output logic [1:0]           rsp_tuser,   // overflow, degenerate
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COORD_BITS-1:0] csr_data
);

   typedef enum logic [3:0] {
      ST_LOAD, ST_CHECK, ST_FB0, ST_FB1, ST_SRD, ST_FIRST, ST_EDGE, ST_DECIDE,
      ST_CROSS, ST_EMIT_E, ST_NEXT, ST_SIDE_END, ST_OUT_RD, ST_OUT_LD, ST_OUT_WAIT
   } state_type;

   state_type state_ff;
   coord_type xl_ff, xh_ff, yl_ff, yh_ff;
   coord_type min_x_ff, max_x_ff, min_y_ff, max_y_ff;
   logic [CNT_W-1:0] count_ff, n_ff, m_ff, i_ff, k_ff;
   logic ovf_ff, degen_ff, cur_sel_ff, fb_final_ff;
   side_type side_ff;
   point_type s_ff, e_ff;
   point_type store_a_ff [MAX_VERTS];
   point_type store_b_ff [MAX_VERTS];
   point_type rd_a_ff, rd_b_ff;
   point_type rsp_point_ff;
   logic rsp_valid_ff, rsp_last_ff, rsp_ovf_ff, rsp_degen_ff;

   coord_type in_x, in_y, cross_c, sx, sy, ex, ey;
   logic req_fire, rsp_fire, s_in, e_in, disjoint;
   logic wr_en, wr_sel_b, emit_fire;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   point_type wr_data, emit_data, rdata, cross_pt;
   logic [CNT_W-1:0] walk_j, walk_nxt;
   cross_req_type cross_req;
   logic cross_start, cross_done;
   coord_type cross_res;

   prc_cross_unit u_cross (
      .clock  (clock),
      .reset  (reset),
      .start  (cross_start),
      .req    (cross_req),
      .done   (cross_done),
      .result (cross_res)
   );

   assign req_tready = (state_ff == ST_LOAD);
   assign csr_ready  = 1'b1;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_valid_ff && rsp_tready;
   assign in_x = coord_type'(req_tdata[COORD_BITS-1:0]);
   assign in_y = coord_type'(req_tdata[POINT_W-1:COORD_BITS]);
   assign rdata = cur_sel_ff ? rd_b_ff : rd_a_ff;

   always_comb begin
      sx = point_x(s_ff);
      sy = point_y(s_ff);
      ex = point_x(e_ff);
      ey = point_y(e_ff);
      unique case (side_ff)
         SIDE_TOP:    begin s_in = (sy <= yh_ff); e_in = (ey <= yh_ff); cross_c = yh_ff; end
         SIDE_BOTTOM: begin s_in = (sy >= yl_ff); e_in = (ey >= yl_ff); cross_c = yl_ff; end
         SIDE_LEFT:   begin s_in = (sx >= xl_ff); e_in = (ex >= xl_ff); cross_c = xl_ff; end
         default:     begin s_in = (sx <= xh_ff); e_in = (ex <= xh_ff); cross_c = xh_ff; end
      endcase
      if (side_ff == SIDE_TOP || side_ff == SIDE_BOTTOM) begin
         cross_req = '{a: sx, b: ex, p: sy, q: ey, c: cross_c};
         cross_pt  = pack_point(cross_res, cross_c);
      end else begin
         cross_req = '{a: sy, b: ey, p: sx, q: ex, c: cross_c};
         cross_pt  = pack_point(cross_c, cross_res);
      end
      cross_start = (state_ff == ST_DECIDE) && (s_in != e_in);
      disjoint = (xl_ff > max_x_ff) || (min_x_ff > xh_ff) ||
                 (yl_ff > max_y_ff) || (min_y_ff > yh_ff);
   end

   // memory access: index of the edge end point follows the edge start
   always_comb begin
      walk_j   = (state_ff == ST_NEXT) ? i_ff + 1'b1 : i_ff;
      walk_nxt = (CNT_W'(walk_j + 1'b1) < n_ff) ? CNT_W'(walk_j + 1'b1) : '0;
      emit_fire = 1'b0;
      emit_data = e_ff;
      priority if (state_ff == ST_DECIDE && s_in == e_in && e_in) emit_fire = 1'b1;
      else if (state_ff == ST_CROSS && cross_done) begin
         emit_fire = 1'b1;
         emit_data = cross_pt;
      end else if (state_ff == ST_EMIT_E) emit_fire = 1'b1;
      else emit_fire = 1'b0;
      wr_en    = 1'b0;
      wr_sel_b = 1'b0;
      wr_addr  = '0;
      wr_data  = emit_data;
      rd_addr  = walk_nxt[ADDR_W-1:0];
      priority if (req_fire && count_ff < CNT_W'(MAX_VERTS)) begin
         wr_en   = 1'b1;
         wr_addr = count_ff[ADDR_W-1:0];
         wr_data = pack_point(in_x, in_y);
      end else if (state_ff == ST_FB0 || state_ff == ST_FB1) begin
         wr_en    = 1'b1;
         wr_sel_b = cur_sel_ff;
         wr_addr  = (state_ff == ST_FB1) ? ADDR_W'(1) : '0;
         wr_data  = pack_point(xl_ff, (state_ff == ST_FB1) ? yh_ff : yl_ff);
      end else if (emit_fire && m_ff < CNT_W'(MAX_VERTS)) begin
         wr_en    = 1'b1;
         wr_sel_b = !cur_sel_ff;
         wr_addr  = m_ff[ADDR_W-1:0];
      end else wr_en = 1'b0;
      priority if (state_ff == ST_SRD) rd_addr = '0;
      else if (state_ff == ST_OUT_RD) rd_addr = k_ff[ADDR_W-1:0];
      else rd_addr = walk_nxt[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (wr_en && !wr_sel_b) store_a_ff[wr_addr] <= wr_data;
      if (wr_en && wr_sel_b)  store_b_ff[wr_addr] <= wr_data;
      rd_a_ff <= store_a_ff[rd_addr];
      rd_b_ff <= store_b_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         xl_ff <= '0;
         xh_ff <= coord_type'(1023);
         yl_ff <= '0;
         yh_ff <= coord_type'(1023);
         min_x_ff <= COORD_MAX;
         min_y_ff <= COORD_MAX;
         max_x_ff <= COORD_MIN;
         max_y_ff <= COORD_MIN;
         count_ff <= '0;
         ovf_ff <= 1'b0;
         degen_ff <= 1'b0;
         cur_sel_ff <= 1'b0;
         fb_final_ff <= 1'b0;
         side_ff <= SIDE_TOP;
         n_ff <= '0;
         m_ff <= '0;
         i_ff <= '0;
         k_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_X_LOW:  xl_ff <= coord_type'(csr_data);
               CSR_X_HIGH: xh_ff <= coord_type'(csr_data);
               CSR_Y_LOW:  yl_ff <= coord_type'(csr_data);
               CSR_Y_HIGH: yh_ff <= coord_type'(csr_data);
               default: ;
            endcase
         end
         if (emit_fire) begin
            if (m_ff < CNT_W'(MAX_VERTS)) m_ff <= m_ff + 1'b1;
            else ovf_ff <= 1'b1;
         end
         unique case (state_ff)
            ST_LOAD: begin
               if (req_fire) begin
                  if (count_ff < CNT_W'(MAX_VERTS)) begin
                     count_ff <= count_ff + 1'b1;
                     if (in_x < min_x_ff) min_x_ff <= in_x;
                     if (in_x > max_x_ff) max_x_ff <= in_x;
                     if (in_y < min_y_ff) min_y_ff <= in_y;
                     if (in_y > max_y_ff) max_y_ff <= in_y;
                  end else begin
                     ovf_ff <= 1'b1;
                  end
                  if (req_tlast) state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               side_ff <= SIDE_TOP;
               if (count_ff == '0 || disjoint) begin
                  degen_ff    <= 1'b1;
                  fb_final_ff <= 1'b1;
                  n_ff        <= CNT_W'(2);
                  state_ff    <= ST_FB0;
               end else begin
                  n_ff     <= count_ff;
                  state_ff <= ST_SRD;
               end
            end
            ST_FB0: state_ff <= ST_FB1;
            ST_FB1: begin
               k_ff     <= '0;
               state_ff <= fb_final_ff ? ST_OUT_RD : ST_SRD;
            end
            ST_SRD: begin
               m_ff     <= '0;
               i_ff     <= '0;
               state_ff <= ST_FIRST;
            end
            ST_FIRST: begin
               s_ff     <= rdata;
               state_ff <= ST_EDGE;
            end
            ST_EDGE: begin
               e_ff     <= rdata;
               state_ff <= ST_DECIDE;
            end
            ST_DECIDE: state_ff <= (s_in != e_in) ? ST_CROSS : ST_NEXT;
            ST_CROSS: begin
               if (cross_done) state_ff <= e_in ? ST_EMIT_E : ST_NEXT;
            end
            ST_EMIT_E: state_ff <= ST_NEXT;
            ST_NEXT: begin
               s_ff <= e_ff;
               i_ff <= i_ff + 1'b1;
               state_ff <= (CNT_W'(i_ff + 1'b1) == n_ff) ? ST_SIDE_END : ST_EDGE;
            end
            ST_SIDE_END: begin
               cur_sel_ff <= !cur_sel_ff;
               side_ff    <= side_ff + 1'b1;
               k_ff       <= '0;
               if (m_ff == '0) begin
                  // side left nothing: restart from the two-point fallback
                  degen_ff    <= 1'b1;
                  fb_final_ff <= (side_ff == SIDE_RIGHT);
                  n_ff        <= CNT_W'(2);
                  state_ff    <= ST_FB0;
               end else begin
                  n_ff     <= m_ff;
                  state_ff <= (side_ff == SIDE_RIGHT) ? ST_OUT_RD : ST_SRD;
               end
            end
            ST_OUT_RD: state_ff <= ST_OUT_LD;
            ST_OUT_LD: begin
               rsp_point_ff <= rdata;
               rsp_last_ff  <= (CNT_W'(k_ff + 1'b1) == n_ff);
               rsp_ovf_ff   <= ovf_ff;
               rsp_degen_ff <= degen_ff;
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
               if (rsp_fire) begin
                  rsp_valid_ff <= 1'b0;
                  k_ff <= k_ff + 1'b1;
                  if (CNT_W'(k_ff + 1'b1) == n_ff) begin
                     count_ff    <= '0;
                     min_x_ff    <= COORD_MAX;
                     min_y_ff    <= COORD_MAX;
                     max_x_ff    <= COORD_MIN;
                     max_y_ff    <= COORD_MIN;
                     ovf_ff      <= 1'b0;
                     degen_ff    <= 1'b0;
                     cur_sel_ff  <= 1'b0;
                     fb_final_ff <= 1'b0;
                     state_ff    <= ST_LOAD;
                  end else begin
                     state_ff <= ST_OUT_RD;
                  end
               end
            end
            default: state_ff <= ST_LOAD;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_W'(rsp_point_ff);
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_degen_ff, rsp_ovf_ff};

   a_no_load_during_output: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_valid_ff)
      else $error("vertex load open while a result is pending");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CNT_W'(MAX_VERTS)) && (m_ff <= CNT_W'(MAX_VERTS)))
      else $error("vertex count beyond store depth");
   a_edge_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) |-> (i_ff < n_ff))
      else $error("edge walk past polygon end");
   a_cross_done_waited: assert property (@(posedge clock) disable iff (reset)
      cross_done |-> (state_ff == ST_CROSS))
      else $error("crossing result with no edge waiting");

endmodule

// File: tb/sv/polygon_rectangle_clipper_checker.sv
// Checker for the polygon rectangle clipper: watches the req, rsp and csr channels,
// predicts the clipped polygon of every closed input polygon and compares results.
// Depends on prc_pkg.
module polygon_rectangle_clipper_checker import prc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [TDATA_W-1:0]    req_tdata,
   input  logic                  req_tlast,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [TDATA_W-1:0]    rsp_tdata,
   input  logic                  rsp_tlast,
   input  logic [1:0]            rsp_tuser,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [COORD_BITS-1:0] csr_data,
   output int                    fail_count,
   output int                    pending,
   output int                    point_count,
   output int                    polygon_count
);

   localparam int MAX_RESULTS = 64;

   typedef struct {
      coord_type x;
      coord_type y;
      logic      last;
      logic      ovf;
      logic      degen;
   } clip_point_type;

   clip_point_type clipped_points[$];

   longint rect_x_low, rect_x_high, rect_y_low, rect_y_high;
   point_type ring [2][MAX_VERTS];
   int     verts_held;
   longint box_x_min, box_x_max, box_y_min, box_y_max;
   bit     verts_lost;

   function automatic longint sx(point_type p);
      return longint'(signed'(p[COORD_BITS-1:0]));
   endfunction

   function automatic longint sy(point_type p);
      return longint'(signed'(p[POINT_W-1:COORD_BITS]));
   endfunction

   function automatic point_type mk(longint x, longint y);
      return {y[COORD_BITS-1:0], x[COORD_BITS-1:0]};
   endfunction

   task automatic reset_polygon();
      verts_held = 0;
      box_x_min  = 32767;
      box_y_min  = 32767;
      box_x_max  = -32768;
      box_y_max  = -32768;
      verts_lost = 0;
   endtask

   function automatic bit keeps(side_type side, point_type p);
      case (side)
         SIDE_TOP:    return sy(p) <= rect_y_high;
         SIDE_BOTTOM: return sy(p) >= rect_y_low;
         SIDE_LEFT:   return sx(p) >= rect_x_low;
         default:     return sx(p) <= rect_x_high;
      endcase
   endfunction

   // exact a + (b - a) * (c - p) / (q - p), truncated toward zero
   function automatic longint cut_coord(longint a, longint b, longint p, longint q,
                                        longint c);
      longint d, num;
      d = q - p;
      if (d == 0) return b;
      num = a * d + (b - a) * (c - p);
      if (d < 0) begin
         d   = -d;
         num = -num;
      end
      return num / d;
   endfunction

   function automatic point_type cut_point(side_type side, point_type s, point_type e);
      case (side)
         SIDE_TOP:
            return mk(cut_coord(sx(s), sx(e), sy(s), sy(e), rect_y_high), rect_y_high);
         SIDE_BOTTOM:
            return mk(cut_coord(sx(s), sx(e), sy(s), sy(e), rect_y_low), rect_y_low);
         SIDE_LEFT:
            return mk(rect_x_low, cut_coord(sy(s), sy(e), sx(s), sx(e), rect_x_low));
         default:
            return mk(rect_x_high, cut_coord(sy(s), sy(e), sx(s), sx(e), rect_x_high));
      endcase
   endfunction

   task automatic put_point(int dst, ref int m, input point_type p);
      if (m < MAX_VERTS) begin
         ring[dst][m] = p;
         m++;
      end else begin
         verts_lost = 1;
      end
   endtask

   task automatic clip_vertex(coord_type x, coord_type y, logic closing);
      int cur, n, m;
      bit degen;
      point_type s, e;
      side_type side;
      clip_point_type pt;
      if (verts_held < MAX_VERTS) begin
         ring[0][verts_held] = {y, x};
         verts_held++;
         if (x < box_x_min) box_x_min = x;
         if (x > box_x_max) box_x_max = x;
         if (y < box_y_min) box_y_min = y;
         if (y > box_y_max) box_y_max = y;
      end else begin
         verts_lost = 1;
      end
      if (!closing) return;
      polygon_count++;
      n = verts_held;
      cur = 0;
      degen = 0;
      if (n == 0 || rect_x_low > box_x_max || box_x_min > rect_x_high ||
          rect_y_low > box_y_max || box_y_min > rect_y_high) begin
         ring[0][0] = mk(rect_x_low, rect_y_low);
         ring[0][1] = mk(rect_x_low, rect_y_high);
         n = 2;
         degen = 1;
      end else begin
         for (int k = 0; k < 4; k++) begin
            side = side_type'(k);
            m = 0;
            for (int i = 0; i < n; i++) begin
               s = ring[cur][i];
               e = ring[cur][(i + 1 < n) ? i + 1 : 0];
               if (keeps(side, e)) begin
                  if (!keeps(side, s)) put_point(1 - cur, m, cut_point(side, s, e));
                  put_point(1 - cur, m, e);
               end else if (keeps(side, s)) begin
                  put_point(1 - cur, m, cut_point(side, s, e));
               end
            end
            cur = 1 - cur;
            n = m;
            if (n == 0) begin
               ring[cur][0] = mk(rect_x_low, rect_y_low);
               ring[cur][1] = mk(rect_x_low, rect_y_high);
               n = 2;
               degen = 1;
            end
         end
      end
      if (n > MAX_RESULTS) begin
         n = MAX_RESULTS;
         verts_lost = 1;
      end
      for (int k = 0; k < n; k++) begin
         pt.x     = ring[cur][k][COORD_BITS-1:0];
         pt.y     = ring[cur][k][POINT_W-1:COORD_BITS];
         pt.last  = (k + 1 == n);
         pt.ovf   = verts_lost;
         pt.degen = degen;
         clipped_points.insert(clipped_points.size(), pt);
      end
      reset_polygon();
   endtask

   task automatic check_point();
      clip_point_type want, got;
      got.x     = rsp_tdata[COORD_BITS-1:0];
      got.y     = rsp_tdata[POINT_W-1:COORD_BITS];
      got.last  = rsp_tlast;
      got.ovf   = rsp_tuser[0];
      got.degen = rsp_tuser[1];
      point_count++;
      if (clipped_points.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("checker: unexpected point x=%0d y=%0d", got.x, got.y);
         return;
      end
      want = clipped_points.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.last !== want.last ||
          got.ovf !== want.ovf || got.degen !== want.degen) begin
         fail_count++;
         if (fail_count <= 10) begin
            $display("checker: point %0d expected x=%0d y=%0d last=%b ovf=%b degen=%b",
                     point_count, want.x, want.y, want.last, want.ovf, want.degen);
            $display("checker: point %0d got      x=%0d y=%0d last=%b ovf=%b degen=%b",
                     point_count, got.x, got.y, got.last, got.ovf, got.degen);
         end
      end
   endtask

   initial begin
      fail_count    = 0;
      pending       = 0;
      point_count   = 0;
      polygon_count = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rect_x_low  = 0;
         rect_x_high = 1023;
         rect_y_low  = 0;
         rect_y_high = 1023;
         reset_polygon();
         clipped_points.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_X_LOW:  rect_x_low  = longint'(signed'(csr_data));
               CSR_X_HIGH: rect_x_high = longint'(signed'(csr_data));
               CSR_Y_LOW:  rect_y_low  = longint'(signed'(csr_data));
               CSR_Y_HIGH: rect_y_high = longint'(signed'(csr_data));
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            clip_vertex(req_tdata[COORD_BITS-1:0], req_tdata[POINT_W-1:COORD_BITS],
                        req_tlast);
         if (rsp_tvalid && rsp_tready)
            check_point();
      end
      pending = clipped_points.size();
   end

endmodule

// File: tb/sv/polygon_rectangle_clipper_tb.sv
// Testbench top for the polygon rectangle clipper: clock, reset, vertex and
// register stimulus, result back-pressure and the verdict.
// Depends on prc_pkg, polygon_rectangle_clipper and polygon_rectangle_clipper_checker.
module polygon_rectangle_clipper_tb;
   import prc_pkg::*;

   localparam int IDLE_LIMIT = 100000;
   localparam int LONG_HOLD  = 3000;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid, req_tready, req_tlast;
   logic [TDATA_W-1:0]    req_tdata;
   logic                  rsp_tvalid, rsp_tready, rsp_tlast;
   logic [TDATA_W-1:0]    rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [COORD_BITS-1:0] csr_data;

   int fail_count, pending, point_count, polygon_count;
   int vertices_sent, idle_cycles, burst_left, hold_asks, holds_done, cyc;
   bit gaps_on;
   longint xl, xh, yl, yh;

   polygon_rectangle_clipper dut (.*);

   polygon_rectangle_clipper_checker chk (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // watchdog: cycles without any transfer
   always @(posedge clock) begin
      cyc++;
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // result side: rotating stall pattern plus an occasional long hold-off
   initial begin
      rsp_tready = 1'b0;
      holds_done = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_asks > holds_done) begin
            rsp_tready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            holds_done++;
         end else begin
            case ((cyc / 700) % 3)
               0: rsp_tready = 1'b1;
               1: rsp_tready = 1'($urandom_range(1));
               default: rsp_tready = ($urandom_range(3) == 0);
            endcase
            @(negedge clock);
         end
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, longint value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value[COORD_BITS-1:0];
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic drain();
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic set_rect(longint x_lo, longint x_hi, longint y_lo, longint y_hi);
      drain();
      write_reg(CSR_X_LOW, x_lo);
      write_reg(CSR_X_HIGH, x_hi);
      write_reg(CSR_Y_LOW, y_lo);
      write_reg(CSR_Y_HIGH, y_hi);
      xl = x_lo;
      xh = x_hi;
      yl = y_lo;
      yh = y_hi;
   endtask

   task automatic send_vertex(longint x, longint y, bit closing);
      if (gaps_on && burst_left == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(8)) @(negedge clock);
         burst_left = $urandom_range(1, 20);
      end
      if (burst_left > 0) burst_left--;
      req_tvalid = 1'b1;
      req_tdata  = {y[COORD_BITS-1:0], x[COORD_BITS-1:0]};
      req_tlast  = closing;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      vertices_sent++;
   endtask

   function automatic longint clamp16(longint v);
      return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
   endfunction

   function automatic longint span_pick(longint a, longint b);
      longint lo, hi, margin;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      margin = (hi - lo) / 3 + 8;
      lo = clamp16(lo - margin);
      hi = clamp16(hi + margin);
      return lo + longint'($urandom_range(int'(hi - lo)));
   endfunction

   // style 0: near the rectangle, 1: anywhere, 2: zigzag across the top edge
   task automatic send_polygon(int nv, int style);
      longint x, y;
      for (int i = 0; i < nv; i++) begin
         case (style)
            0: begin
               x = span_pick(xl, xh);
               y = span_pick(yl, yh);
            end
            1: begin
               x = longint'($urandom_range(65535)) - 32768;
               y = longint'($urandom_range(65535)) - 32768;
            end
            default: begin
               x = clamp16(xl + (xh - xl) * i / nv + longint'($urandom_range(3)));
               y = (i % 2) ? clamp16(yh + longint'($urandom_range(1, 50)))
                           : clamp16(yh - longint'($urandom_range(1, 50)));
            end
         endcase
         send_vertex(x, y, i == nv - 1);
      end
   endtask

   task automatic random_phase(int items, bit long_hold);
      int sent, nv, pick, style;
      sent = 0;
      gaps_on = $urandom_range(3) != 0;
      while (sent < items) begin
         pick = $urandom_range(99);
         if (pick < 5)       nv = $urandom_range(1, 2);
         else if (pick < 90) nv = $urandom_range(3, 8);
         else                nv = $urandom_range(20, 70);
         pick = $urandom_range(99);
         style = (pick < 60) ? 0 : (pick < 85) ? 1 : 2;
         if (long_hold && sent > items / 2) begin
            hold_asks++;
            long_hold = 0;
            nv = 30;
         end
         send_polygon(nv, style);
         sent += nv;
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      cyc = 0;
      idle_cycles = 0;
      hold_asks = 0;
      burst_left = 0;
      vertices_sent = 0;
      gaps_on = 0;
      xl = 0; xh = 1023; yl = 0; yh = 1023;
      repeat (9) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed polygons against the reset rectangle
      send_vertex(5, 5, 1);
      send_vertex(10, 10, 0); send_vertex(100, 10, 0); send_vertex(50, 90, 1);
      send_vertex(-100, 500, 0); send_vertex(500, -100, 0);
      send_vertex(1200, 500, 0); send_vertex(500, 1200, 1);
      send_vertex(2000, 2000, 0); send_vertex(3000, 2000, 0); send_vertex(2500, 3000, 1);
      send_vertex(-32768, -32768, 0); send_vertex(32767, -32768, 0);
      send_vertex(32767, 32767, 0); send_vertex(-32768, 32767, 1);
      // box overlaps the rectangle but the polygon does not: a side comes out empty
      send_vertex(1000, 1100, 0); send_vertex(1100, 1000, 0); send_vertex(1100, 1100, 1);
      // repeated vertex and vertical edges
      send_vertex(-50, 200, 0); send_vertex(-50, 200, 0); send_vertex(-50, 900, 1);
      // a full store: 66 vertices, the last ones dropped
      drain();
      send_polygon(66, 1);

      gaps_on = 1;
      random_phase(50, 0);
      set_rect(-32768, 32767, -32768, 32767);
      random_phase(50, 0);
      set_rect(-20, 20, -10, 30);
      random_phase(70, 1);
      set_rect(100, -100, 50, -50);
      random_phase(30, 0);
      set_rect(longint'($urandom_range(4000)) - 3000, longint'($urandom_range(4000)) + 1000,
               longint'($urandom_range(4000)) - 3000, longint'($urandom_range(4000)) + 1000);
      random_phase(70, 0);
      set_rect(7, 7, 7, 7);
      random_phase(30, 0);
      set_rect(-300, 32767, -32768, 300);
      random_phase(50, 0);

      drain();
      repeat (60) @(negedge clock);
      $display("tb: %0d vertices in %0d polygons, %0d clipped points checked",
               vertices_sent, polygon_count, point_count);
      $display("tb: seven rectangles incl. full range, inverted and single point");
      if (fail_count == 0 && pending == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
